[rtl/bus_frame_receive_validator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bus frame receive validator
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUS_FRAME_RECEIVE_VALIDATOR_ASSERT_SVH
`define BUS_FRAME_RECEIVE_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFRV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bus frame receive validator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bus frame receive validator check failed");

`endif

[rtl/bfrv_pkg.sv]
// ----------------------------------------------------------------------------
// bfrv_pkg
// Types, codes and constants shared by the frame receive validator files.
// ----------------------------------------------------------------------------
package bfrv_pkg;

  // Default depth of the frame byte store.
  localparam int STORE_BYTES_DEF = 24;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Phase codes reported with each result.
  localparam logic [2:0] PHASE_HUNT = 3'd0;
  localparam logic [2:0] PHASE_DEST = 3'd1;
  localparam logic [2:0] PHASE_SRC  = 3'd2;
  localparam logic [2:0] PHASE_BODY = 3'd3;
  localparam logic [2:0] PHASE_HELD = 3'd4;

  // Frame format constants.
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hAB;
  localparam logic [7:0] HI_MASK    = 8'hF0;
  localparam logic [7:0] DEST_TAG   = 8'hD0;
  localparam logic [7:0] SRC_TAG    = 8'hE0;
  localparam logic [7:0] MAX_LEN    = 8'd20;
  localparam logic [7:0] SRC_POS    = 8'd2;
  localparam logic [7:0] LEN_POS    = 8'd4;
  localparam logic [7:0] BODY_POS   = 8'd5;
  localparam logic [7:0] CSUM_OFS   = 8'd4;
  localparam logic [7:0] END_OFS    = 8'd5;
  localparam logic [3:0] SLOT_RESET = 4'd4;

  // Receive state machine, one-hot.
  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_DEST = 5'b00010,
    ST_SRC  = 5'b00100,
    ST_BODY = 5'b01000,
    ST_HELD = 5'b10000
  } rx_state_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [4:0] read_index;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0] phase;
    logic       frame_ready;
    logic       dropped;
    logic [4:0] frame_length;
    logic [3:0] slot_number;
    logic [7:0] read_data;
  } out_item_t;

  // Configuration write payload.
  typedef struct packed {
    logic no_checksum;
  } cfg_item_t;

  // Status produced by the parser for one transaction.
  typedef struct packed {
    logic [2:0] phase;
    logic       frame_ready;
    logic       dropped;
    logic [4:0] frame_length;
    logic [3:0] slot_number;
  } parse_stat_t;

  // Map a state to its reported phase code.
  function automatic logic [2:0] phase_code(rx_state_t st);
    logic [2:0] code;
    case (st)
      ST_HUNT: code = PHASE_HUNT;
      ST_DEST: code = PHASE_DEST;
      ST_SRC:  code = PHASE_SRC;
      ST_BODY: code = PHASE_BODY;
      ST_HELD: code = PHASE_HELD;
      default: code = PHASE_HUNT;
    endcase
    return code;
  endfunction

endpackage

[rtl/bfrv_chan_if.sv]
// ----------------------------------------------------------------------------
// bfrv_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface bfrv_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bus_frame_receive_validator.sv]
// ----------------------------------------------------------------------------
// bus_frame_receive_validator
// Hunts received bytes for a bus frame, checks it and holds it for readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per accepted valid/ready handshake: a
//   received byte, a release of the held frame, or a read of a stored byte.
//   out_ch returns exactly one result per input transaction, in order, with
//   the phase, frame_ready, dropped, frame length, slot and read data.
//   cfg_ch writes the no_checksum register; it is always ready and should be
//   written only while no transaction is in flight.
// Latency and throughput:
//   Results are registered. One transaction per cycle is sustained while
//   out_ch.ready is high; the parser state and the store write port both
//   update in the accepting cycle, so the next byte sees them at once.
// Reset:
//   rst_n clears the parser to hunting, the slot to 4 and no_checksum to 0.
//   Store contents are undefined until written.
// Backpressure:
//   The result register holds while out_ch.ready is low; in_ch.ready stays
//   high while the result register is empty or is being drained.
// ----------------------------------------------------------------------------
`include "bus_frame_receive_validator_assert.svh"

module bus_frame_receive_validator #(
  parameter int STORE_BYTES = bfrv_pkg::STORE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfrv_chan_if.sink   in_ch,
  bfrv_chan_if.source out_ch,
  bfrv_chan_if.sink   cfg_ch
);
  import bfrv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic          in_accept;
  logic          cfg_accept;
  logic          no_checksum_r;
  logic          out_valid_r, out_valid_nxt;
  parse_stat_t   stat_nxt;
  parse_stat_t   out_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;
  in_item_t      in_item;
  cfg_item_t     cfg_item;

  assign in_item    = in_ch.data;
  assign cfg_item   = cfg_ch.data;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign cfg_accept = cfg_ch.valid && cfg_ch.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_checksum_r <= 1'b0;
    end else if (cfg_accept) begin
      no_checksum_r <= cfg_item.no_checksum;
    end
  end

  bfrv_parser #(
    .STORE_BYTES (STORE_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (in_accept && in_item.action == ACT_BYTE),
    .release_en  (in_accept && in_item.action == ACT_RELEASE),
    .data_byte   (in_item.data_byte),
    .no_checksum (no_checksum_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .stat        (stat_nxt)
  );

  bfrv_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_item.data_byte),
    .rd_en    (in_accept),
    .rd_sel   (in_item.action == ACT_READ),
    .rd_index (in_item.read_index),
    .rd_data  (rd_data)
  );

  // Result register: loads on each accepted transaction, drains on out ready.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= stat_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = '{
    phase:        out_r.phase,
    frame_ready:  out_r.frame_ready,
    dropped:      out_r.dropped,
    frame_length: out_r.frame_length,
    slot_number:  out_r.slot_number,
    read_data:    rd_data
  };

  // A completed frame is always reported in the held phase.
  `BFRV_ASSERT_SAME(a_ready_is_held, clk, rst_n, out_valid_r && out_r.frame_ready, out_r.phase == PHASE_HELD)
  // A dropped frame always returns to hunting.
  `BFRV_ASSERT_SAME(a_drop_is_hunt, clk, rst_n, out_valid_r && out_r.dropped, out_r.phase == PHASE_HUNT)
  // A byte cannot both complete and abort a frame.
  `BFRV_ASSERT_SAME(a_ready_drop_excl, clk, rst_n, out_valid_r, !(out_r.frame_ready && out_r.dropped))
  // A read transaction yields a result with no frame event.
  `BFRV_ASSERT_NEXT(a_read_no_event, clk, rst_n, in_accept && in_item.action == ACT_READ, out_valid_r && !out_r.frame_ready && !out_r.dropped)

endmodule

[rtl/bfrv_store.sv]
// ----------------------------------------------------------------------------
// bfrv_store
// Frame byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfrv_store #(
  parameter int STORE_BYTES = bfrv_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_BYTES)-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           rd_en,
  input  logic                           rd_sel,
  input  logic [4:0]                     rd_index,
  output logic [7:0]                     rd_data
);
  import bfrv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [7:0]    idx_ext;
  logic          rd_hit;
  logic [AW-1:0] rd_addr;

  // An index beyond the store, or any non-read transaction, returns zero.
  assign idx_ext = 8'(rd_index);
  assign rd_hit  = rd_sel && (idx_ext < 8'(STORE_BYTES));
  assign rd_addr = idx_ext[AW-1:0];

  // Byte writes from the parser.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, updated only when a transaction is taken.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rd_hit ? mem[rd_addr] : 8'd0;
    end
  end

  assign rd_data = rd_data_r;
endmodule

[rtl/bfrv_parser.sv]
// ----------------------------------------------------------------------------
// bfrv_parser
// Frame hunting state machine with byte count, running sum and slot latch.
// ----------------------------------------------------------------------------
module bfrv_parser #(
  parameter int STORE_BYTES = bfrv_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           byte_en,
  input  logic                           release_en,
  input  logic [7:0]                     data_byte,
  input  logic                           no_checksum,
  output logic                           wr_en,
  output logic [$clog2(STORE_BYTES)-1:0] wr_addr,
  output bfrv_pkg::parse_stat_t          stat
);
  import bfrv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);

  rx_state_t     state_r, state_nxt, tgt;
  logic [CW-1:0] count_r, count_nxt, cnt_base;
  logic [7:0]    sum_r, sum_nxt, sum_base;
  logic [4:0]    len_r, len_nxt;
  logic [3:0]    src_r, src_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [7:0]    cnt8, base8, len8, next8;
  logic          frame_ready, dropped;

  assign cnt8  = 8'(count_r);
  assign base8 = 8'(cnt_base);
  assign len8  = 8'(len_r);
  assign next8 = 8'(count_nxt);

  // Next-state logic for one transaction.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    src_nxt     = src_r;
    slot_nxt    = slot_r;
    cnt_base    = count_r;
    sum_base    = sum_r;
    tgt         = state_r;
    wr_en       = 1'b0;
    frame_ready = 1'b0;
    dropped     = 1'b0;
    if (byte_en && state_r != ST_HELD) begin
      case (state_r)
        ST_HUNT: begin
          if (data_byte == START_BYTE) begin
            cnt_base = '0;
            sum_base = 8'd0;
            tgt      = ST_DEST;
          end
        end
        ST_DEST: begin
          tgt = ((data_byte & HI_MASK) == DEST_TAG) ? ST_SRC : ST_HUNT;
        end
        ST_SRC: begin
          tgt = ((data_byte & HI_MASK) == SRC_TAG) ? ST_BODY : ST_HUNT;
        end
        ST_BODY: begin
          if (cnt8 == LEN_POS && data_byte > MAX_LEN) begin
            tgt = ST_HUNT;
          end else if (cnt8 >= BODY_POS) begin
            if (!no_checksum && (len8 + CSUM_OFS) == cnt8) begin
              if (sum_r != data_byte) begin
                tgt = ST_HUNT;
              end
            end else if (data_byte == END_BYTE && (len8 + END_OFS) == cnt8) begin
              slot_nxt = src_r;
              tgt      = ST_HELD;
            end
          end
        end
        default: begin
          tgt = state_r;
        end
      endcase
      // Store the byte at the next position, or drop when the store is full.
      if (tgt != ST_HUNT) begin
        if (base8 < 8'(STORE_BYTES)) begin
          wr_en     = 1'b1;
          count_nxt = cnt_base + CW'(1);
          sum_nxt   = sum_base + data_byte;
          if (base8 == SRC_POS) begin
            src_nxt = data_byte[3:0];
          end
          if (base8 == LEN_POS) begin
            len_nxt = data_byte[4:0];
          end
        end else begin
          tgt = ST_HUNT;
        end
      end
      dropped     = (state_r != ST_HUNT) && (tgt == ST_HUNT);
      frame_ready = (tgt == ST_HELD);
      state_nxt   = tgt;
    end else if (release_en && state_r == ST_HELD) begin
      state_nxt = ST_HUNT;
    end
  end

  assign wr_addr = cnt_base[AW-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      count_r <= '0;
      sum_r   <= 8'd0;
      slot_r  <= SLOT_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Shadow copies of the source nibble and length byte of the current frame.
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    src_r <= src_nxt;
  end

  assign stat = '{
    phase:        phase_code(state_nxt),
    frame_ready:  frame_ready,
    dropped:      dropped,
    frame_length: next8[4:0],
    slot_number:  slot_nxt
  };
endmodule
